>>> design/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and codes for the true-LRU replacement cache: search chain
// link, update broadcast and entry class codes.
// ----------------------------------------------------------------------------
package lrc_pkg;

  // entry class seen by the search chain, higher wins
  localparam logic [1:0] CLS_VALID = 2'b00;
  localparam logic [1:0] CLS_EMPTY = 2'b01;
  localparam logic [1:0] CLS_HIT   = 2'b10;

  typedef enum logic [1:0] {
    K_NONE  = 2'b00,
    K_HIT   = 2'b01,
    K_FILL  = 2'b10,
    K_EVICT = 2'b11
  } kind_t;

  typedef struct packed {
    logic       tok;
    logic       found;
    logic [1:0] cls;
  } link_t;

  typedef struct packed {
    logic  go;
    kind_t kind;
  } upd_t;

endpackage

>>> design/lrc_cell.sv
// ----------------------------------------------------------------------------
// lrc_cell
// One cache entry: key, valid flag and LRU age, plus one stage of the search
// chain that carries the best candidate so far towards the last entry.
// ----------------------------------------------------------------------------
module lrc_cell #(
  parameter int IDX_W    = 6,
  parameter int KEY_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_W-1:0]     index,
  input  logic                 active,
  input  logic [KEY_BITS-1:0]  key,
  input  lrc_pkg::link_t       link_in,
  input  logic [IDX_W-1:0]     bidx_in,
  input  logic [IDX_W-1:0]     bage_in,
  input  logic [KEY_BITS-1:0]  bkey_in,
  output lrc_pkg::link_t       link_out,
  output logic [IDX_W-1:0]     bidx_out,
  output logic [IDX_W-1:0]     bage_out,
  output logic [KEY_BITS-1:0]  bkey_out,
  input  lrc_pkg::upd_t        upd,
  input  logic [IDX_W-1:0]     upd_slot,
  input  logic [IDX_W-1:0]     upd_age,
  input  logic [KEY_BITS-1:0]  upd_key,
  input  logic [IDX_W-1:0]     age_max
);
  import lrc_pkg::*;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                valid_r, valid_nxt;
  logic [IDX_W-1:0]    age_r, age_nxt;
  link_t               link_r, link_nxt;
  logic [IDX_W-1:0]    bidx_r, bidx_nxt;
  logic [IDX_W-1:0]    bage_r, bage_nxt;
  logic [KEY_BITS-1:0] bkey_r, bkey_nxt;

  logic       match;
  logic [1:0] cls;
  logic       better;
  logic       is_me;
  logic       can_age;

  assign match = valid_r && (key_r == key);
  assign cls   = match ? CLS_HIT : (!valid_r ? CLS_EMPTY : CLS_VALID);

  // strictly better only, so the lowest slot wins a tie
  assign better = active && (!link_in.found || (cls > link_in.cls) ||
                  ((cls == link_in.cls) && (cls == CLS_VALID) && (age_r > bage_in)));

  always_comb begin
    link_nxt.tok   = link_in.tok;
    link_nxt.found = link_in.found | active;
    link_nxt.cls   = better ? cls : link_in.cls;
    bidx_nxt       = better ? index : bidx_in;
    bage_nxt       = better ? age_r : bage_in;
    bkey_nxt       = better ? key_r : bkey_in;
  end

  assign is_me   = (index == upd_slot);
  assign can_age = valid_r && (age_r < age_max);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    age_nxt   = age_r;
    if (upd.go && active) begin
      case (upd.kind)
        K_HIT: begin
          if (is_me) begin
            age_nxt = '0;
          end else if (can_age && (age_r < upd_age)) begin
            age_nxt = age_r + 1'b1;
          end
        end
        K_FILL: begin
          if (is_me) begin
            key_nxt   = upd_key;
            valid_nxt = 1'b1;
            age_nxt   = '0;
          end else if (can_age) begin
            age_nxt = age_r + 1'b1;
          end
        end
        K_EVICT: begin
          if (is_me) begin
            key_nxt = upd_key;
            age_nxt = '0;
          end else if (can_age && (age_r < upd_age)) begin
            age_nxt = age_r + 1'b1;
          end
        end
        default: begin
          age_nxt = age_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
      link_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      link_r  <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    bidx_r <= bidx_nxt;
    bage_r <= bage_nxt;
    bkey_r <= bkey_nxt;
  end

  assign link_out = link_r;
  assign bidx_out = bidx_r;
  assign bage_out = bage_r;
  assign bkey_out = bkey_r;

endmodule

>>> design/lru_replacement_cache.sv
// the input stalls until the previous access has handed its result to the output
// each access sweeps a search token through the row of entry cells one cell
//   per cycle before the update
// a new access is taken while the previous result still waits on the output
// reset: synchronous active-low, clears all valid flags, ages, hit count,
//   and sets the size register to 64
// ----------------------------------------------------------------------------
// lru_replacement_cache
// Fully associative key store with true LRU replacement, built as a row of
// entry cells with a registered search chain and a broadcast update.
// ----------------------------------------------------------------------------
module lru_replacement_cache #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_entries_in_use,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_access_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [5:0]  out_slot,
  output logic        out_filled_empty,
  output logic        out_evicted,
  output logic [15:0] out_evicted_key,
  output logic [31:0] out_hit_total
);
  import lrc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = ((IDX_W > 7) ? IDX_W : 7) + 1;
  localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SWEEP   = 4'b0010,
    ST_UPDATE  = 4'b0100,
    ST_DELIVER = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [6:0]          size_r, size_nxt;
  logic                start_r, start_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  kind_t               kind_r, kind_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic [IDX_W-1:0]    age_r, age_nxt;
  logic [KEY_BITS-1:0] old_r, old_nxt;
  logic [31:0]         hits_r, hits_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                o_hit_r, o_hit_nxt;
  logic [5:0]          o_slot_r, o_slot_nxt;
  logic                o_fill_r, o_fill_nxt;
  logic                o_evict_r, o_evict_nxt;
  logic [15:0]         o_okey_r, o_okey_nxt;
  logic [31:0]         o_hits_r, o_hits_nxt;

  link_t               link [0:ENTRIES];
  logic [IDX_W-1:0]    bidx [0:ENTRIES];
  logic [IDX_W-1:0]    bage [0:ENTRIES];
  logic [KEY_BITS-1:0] bkey [0:ENTRIES];
  logic [ENTRIES-1:0]  active;
  logic [ENTRIES-1:0]  tok_vec;
  upd_t                upd;
  logic                in_acc;
  logic                out_free;
  link_t               link_end;

  assign link[0] = '{tok: start_r, found: 1'b0, cls: CLS_VALID};
  assign bidx[0] = '0;
  assign bage[0] = '0;
  assign bkey[0] = '0;

  assign upd.go   = (state_r == ST_UPDATE);
  assign upd.kind = kind_r;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign active[g]  = (CNT_W'(g) < CNT_W'(size_r));
    assign tok_vec[g] = link[g+1].tok;

    lrc_cell #(
      .IDX_W    (IDX_W),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .index    (IDX_W'(g)),
      .active   (active[g]),
      .key      (key_r),
      .link_in  (link[g]),
      .bidx_in  (bidx[g]),
      .bage_in  (bage[g]),
      .bkey_in  (bkey[g]),
      .link_out (link[g+1]),
      .bidx_out (bidx[g+1]),
      .bage_out (bage[g+1]),
      .bkey_out (bkey[g+1]),
      .upd      (upd),
      .upd_slot (slot_r),
      .upd_age  (age_r),
      .upd_key  (key_r),
      .age_max  (AGE_MAX)
    );
  end

  assign link_end = link[ENTRIES];
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = cfg_we ? cfg_entries_in_use : size_r;
    start_nxt     = 1'b0;
    key_nxt       = key_r;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    age_nxt       = age_r;
    old_nxt       = old_r;
    hits_nxt      = hits_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_hit_nxt     = o_hit_r;
    o_slot_nxt    = o_slot_r;
    o_fill_nxt    = o_fill_r;
    o_evict_nxt   = o_evict_r;
    o_okey_nxt    = o_okey_r;
    o_hits_nxt    = o_hits_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt   = KEY_BITS'(in_access_key);
          start_nxt = 1'b1;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (link_end.tok) begin
          slot_nxt = link_end.found ? bidx[ENTRIES] : '0;
          age_nxt  = bage[ENTRIES];
          old_nxt  = bkey[ENTRIES];
          if (!link_end.found) begin
            kind_nxt = K_NONE;
          end else if (link_end.cls == CLS_HIT) begin
            kind_nxt = K_HIT;
          end else if (link_end.cls == CLS_EMPTY) begin
            kind_nxt = K_FILL;
          end else begin
            kind_nxt = K_EVICT;
          end
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if ((kind_r == K_HIT) && (hits_r != '1)) begin
          hits_nxt = hits_r + 32'd1;
        end
        state_nxt = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_hit_nxt     = (kind_r == K_HIT);
          o_slot_nxt    = 6'(slot_r);
          o_fill_nxt    = (kind_r == K_FILL);
          o_evict_nxt   = (kind_r == K_EVICT);
          o_okey_nxt    = (kind_r == K_EVICT) ? 16'(old_r) : 16'd0;
          o_hits_nxt    = hits_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= 7'd64;
      start_r     <= 1'b0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= K_NONE;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      start_r     <= start_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    slot_r    <= slot_nxt;
    age_r     <= age_nxt;
    old_r     <= old_nxt;
    o_hit_r   <= o_hit_nxt;
    o_slot_r  <= o_slot_nxt;
    o_fill_r  <= o_fill_nxt;
    o_evict_r <= o_evict_nxt;
    o_okey_r  <= o_okey_nxt;
    o_hits_r  <= o_hits_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = o_hit_r;
  assign out_slot         = o_slot_r;
  assign out_filled_empty = o_fill_r;
  assign out_evicted      = o_evict_r;
  assign out_evicted_key  = o_okey_r;
  assign out_hit_total    = o_hits_r;

  // at most one search token in the row of cells
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one search token in flight");

  // token only leaves the row while sweeping
  a_token_state: assert property (@(posedge clk) disable iff (!rst_n)
    link_end.tok |-> (state_r == ST_SWEEP))
    else $error("search token out of sweep");

  // a hit result carries a non-zero hit count
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_hit_total != 32'd0))
    else $error("hit reported with zero hit count");

  // a result is exactly one of hit, fill, eviction or none
  a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_hit, out_filled_empty, out_evicted}))
    else $error("conflicting outcome flags");

  // update broadcast always follows a completed sweep
  a_update_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> $past(link_end.tok))
    else $error("update without a finished sweep");

endmodule
